### hw/rtl/pwh_pkg.sv
// Package for the pulse-width handshake block: shared types, codes and reset defaults.
// Used by pwh_cfg, pwh_engine and pulse_width_handshake; depends on nothing.
`default_nettype none

package pwh_pkg;

    // Default widths handed to the top-level parameters
    localparam int TIMER_BITS_DEF  = 24;
    localparam int WINDOW_BITS_DEF = 16;

    // Fixed field widths
    localparam int TO_W      = 24;
    localparam int LW_W      = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [LW_W-1:0] LW_MAX = {LW_W{1'b1}};

    // Register reset values
    localparam int SYNC_WIDTH_RST     = 300;
    localparam int FIRST_MIN_RST      = 250;
    localparam int FIRST_MAX_RST      = 400;
    localparam int SECOND_MIN_RST     = 750;
    localparam int SECOND_MAX_RST     = 900;
    localparam int FIRST_TIMEOUT_RST  = 1000000;
    localparam int SECOND_TIMEOUT_RST = 1000000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_WIDTH     = 3'd0,
        REG_FIRST_MIN      = 3'd1,
        REG_FIRST_MAX      = 3'd2,
        REG_SECOND_MIN     = 3'd3,
        REG_SECOND_MAX     = 3'd4,
        REG_FIRST_TIMEOUT  = 3'd5,
        REG_SECOND_TIMEOUT = 3'd6
    } reg_idx_t;

    // Handshake phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYNC = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    // Completion status
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT1 = 3'd1,
        ST_TIMEOUT2 = 3'd2,
        ST_BAD1     = 3'd3,
        ST_BAD2     = 3'd4
    } status_t;

    // One result item
    typedef struct packed {
        logic            drive_low;
        logic            busy_res;
        logic            done_res;
        status_t         status;
        logic            stage;
        logic [LW_W-1:0] last_width;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/pwh_cfg.sv
// Configuration register file for the pulse-width handshake.
// Depends on pwh_pkg for register indexes and reset values.
`default_nettype none

module pwh_cfg #(
    parameter int WINDOW_BITS = pwh_pkg::WINDOW_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pwh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pwh_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic      [WINDOW_BITS-1:0]          sync_width,
    output logic      [WINDOW_BITS-1:0]          first_min,
    output logic      [WINDOW_BITS-1:0]          first_max,
    output logic      [WINDOW_BITS-1:0]          second_min,
    output logic      [WINDOW_BITS-1:0]          second_max,
    output logic      [pwh_pkg::TO_W-1:0]        first_timeout,
    output logic      [pwh_pkg::TO_W-1:0]        second_timeout
);

    logic [WINDOW_BITS-1:0]   sync_width_reg;
    logic [WINDOW_BITS-1:0]   first_min_reg;
    logic [WINDOW_BITS-1:0]   first_max_reg;
    logic [WINDOW_BITS-1:0]   second_min_reg;
    logic [WINDOW_BITS-1:0]   second_max_reg;
    logic [pwh_pkg::TO_W-1:0] first_timeout_reg;
    logic [pwh_pkg::TO_W-1:0] second_timeout_reg;

    logic [WINDOW_BITS-1:0]   win_data;
    logic [pwh_pkg::TO_W-1:0] to_data;

    // Keep the low bits of the write data for each register class
    assign win_data = cfg_data[WINDOW_BITS-1:0];
    assign to_data  = cfg_data[pwh_pkg::TO_W-1:0];

    // Write the selected register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_width_reg     <= WINDOW_BITS'(pwh_pkg::SYNC_WIDTH_RST);
            first_min_reg      <= WINDOW_BITS'(pwh_pkg::FIRST_MIN_RST);
            first_max_reg      <= WINDOW_BITS'(pwh_pkg::FIRST_MAX_RST);
            second_min_reg     <= WINDOW_BITS'(pwh_pkg::SECOND_MIN_RST);
            second_max_reg     <= WINDOW_BITS'(pwh_pkg::SECOND_MAX_RST);
            first_timeout_reg  <= pwh_pkg::TO_W'(pwh_pkg::FIRST_TIMEOUT_RST);
            second_timeout_reg <= pwh_pkg::TO_W'(pwh_pkg::SECOND_TIMEOUT_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwh_pkg::REG_SYNC_WIDTH:     sync_width_reg     <= win_data;
                pwh_pkg::REG_FIRST_MIN:      first_min_reg      <= win_data;
                pwh_pkg::REG_FIRST_MAX:      first_max_reg      <= win_data;
                pwh_pkg::REG_SECOND_MIN:     second_min_reg     <= win_data;
                pwh_pkg::REG_SECOND_MAX:     second_max_reg     <= win_data;
                pwh_pkg::REG_FIRST_TIMEOUT:  first_timeout_reg  <= to_data;
                pwh_pkg::REG_SECOND_TIMEOUT: second_timeout_reg <= to_data;
                default:
                begin
                end
            endcase
        end
    end

    assign sync_width     = sync_width_reg;
    assign first_min      = first_min_reg;
    assign first_max      = first_max_reg;
    assign second_min     = second_min_reg;
    assign second_max     = second_max_reg;
    assign first_timeout  = first_timeout_reg;
    assign second_timeout = second_timeout_reg;

endmodule

`default_nettype wire

### hw/rtl/pwh_engine.sv
// Handshake state and per-item next-state logic: sync timing, pulse timing,
// stage timeouts and width checks. Depends on pwh_pkg.
`default_nettype none

module pwh_engine #(
    parameter int TIMER_BITS  = pwh_pkg::TIMER_BITS_DEF,
    parameter int WINDOW_BITS = pwh_pkg::WINDOW_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     fire,
    input  wire logic                     action,
    input  wire logic                     line_low,
    input  wire logic [WINDOW_BITS-1:0]   sync_width,
    input  wire logic [WINDOW_BITS-1:0]   first_min,
    input  wire logic [WINDOW_BITS-1:0]   first_max,
    input  wire logic [WINDOW_BITS-1:0]   second_min,
    input  wire logic [WINDOW_BITS-1:0]   second_max,
    input  wire logic [pwh_pkg::TO_W-1:0] first_timeout,
    input  wire logic [pwh_pkg::TO_W-1:0] second_timeout,
    output pwh_pkg::result_t              res
);

    localparam int CMP_W = (TIMER_BITS > pwh_pkg::TO_W) ? TIMER_BITS : pwh_pkg::TO_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    pwh_pkg::phase_t        phase_reg, phase_next;
    logic                   stage2_reg, stage2_next;
    logic [TIMER_BITS-1:0]  ticks_reg, ticks_next;
    logic                   measuring_reg, measuring_next;
    logic [TIMER_BITS-1:0]  pulse_reg, pulse_next;
    logic [TIMER_BITS-1:0]  width_reg, width_next;

    logic [TIMER_BITS-1:0]  ticks_inc;
    logic [CMP_W-1:0]       ticks_ext;
    logic [CMP_W-1:0]       width_ext;
    logic [CMP_W-1:0]       limit_ext;
    logic                   completed;
    logic                   timed_out;
    logic                   in_first;
    logic                   in_second;
    logic                   done;
    pwh_pkg::status_t       status;

    // Saturating stage timer step and the common-width views for compares
    assign ticks_inc = (ticks_reg == TIMER_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign ticks_ext = CMP_W'(ticks_inc);
    assign width_ext = CMP_W'(pulse_reg);
    assign limit_ext = stage2_reg ? CMP_W'(second_timeout) : CMP_W'(first_timeout);

    // A pulse completes on the first high sample while measuring
    assign completed = !line_low && measuring_reg;
    assign timed_out = ticks_ext >= limit_ext;
    assign in_first  = (width_ext > CMP_W'(first_min)) && (width_ext < CMP_W'(first_max));
    assign in_second = (width_ext > CMP_W'(second_min)) && (width_ext < CMP_W'(second_max));

    // Next state for one item; start has priority over the current phase
    always_comb
    begin
        phase_next     = phase_reg;
        stage2_next    = stage2_reg;
        ticks_next     = ticks_reg;
        measuring_next = measuring_reg;
        pulse_next     = pulse_reg;
        width_next     = width_reg;
        done           = 1'b0;
        status         = pwh_pkg::ST_OK;

        if (action)
        begin
            phase_next     = pwh_pkg::PH_SYNC;
            stage2_next    = 1'b0;
            ticks_next     = '0;
            measuring_next = 1'b0;
            pulse_next     = '0;
            width_next     = '0;
        end
        else
        begin
            unique case (phase_reg)
                pwh_pkg::PH_SYNC:
                begin
                    if (CMP_W'(ticks_inc) >= CMP_W'(sync_width))
                    begin
                        phase_next     = pwh_pkg::PH_WAIT;
                        ticks_next     = '0;
                        measuring_next = 1'b0;
                        pulse_next     = '0;
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                    end
                end
                pwh_pkg::PH_WAIT:
                begin
                    // Time the low pulse
                    if (line_low)
                    begin
                        if (!measuring_reg)
                        begin
                            measuring_next = 1'b1;
                            pulse_next     = TIMER_BITS'(1);
                        end
                        else
                        begin
                            pulse_next = (pulse_reg == TIMER_MAX) ? pulse_reg
                                                                  : pulse_reg + 1'b1;
                        end
                    end
                    else if (measuring_reg)
                    begin
                        measuring_next = 1'b0;
                        width_next     = pulse_reg;
                    end
                    ticks_next = ticks_inc;

                    // Timeout wins over a pulse completing on the same tick
                    if (timed_out)
                    begin
                        done   = 1'b1;
                        status = stage2_reg ? pwh_pkg::ST_TIMEOUT2 : pwh_pkg::ST_TIMEOUT1;
                    end
                    else if (completed)
                    begin
                        if (in_first)
                        begin
                            stage2_next    = 1'b1;
                            ticks_next     = '0;
                            measuring_next = 1'b0;
                            pulse_next     = '0;
                        end
                        else if (stage2_reg && in_second)
                        begin
                            done   = 1'b1;
                            status = pwh_pkg::ST_OK;
                        end
                        else
                        begin
                            done   = 1'b1;
                            status = stage2_reg ? pwh_pkg::ST_BAD2 : pwh_pkg::ST_BAD1;
                        end
                    end
                    if (done)
                    begin
                        phase_next = pwh_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = pwh_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result item from the state after this item
    always_comb
    begin
        res.drive_low  = (phase_next == pwh_pkg::PH_SYNC);
        res.busy_res   = (phase_next != pwh_pkg::PH_IDLE);
        res.done_res   = done;
        res.status     = status;
        res.stage      = stage2_next;
        res.last_width = (CMP_W'(width_next) > CMP_W'(pwh_pkg::LW_MAX))
                         ? pwh_pkg::LW_MAX : pwh_pkg::LW_W'(width_next);
    end

    // Advance the state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pwh_pkg::PH_IDLE;
            stage2_reg    <= 1'b0;
            ticks_reg     <= '0;
            measuring_reg <= 1'b0;
            pulse_reg     <= '0;
            width_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            stage2_reg    <= stage2_next;
            ticks_reg     <= ticks_next;
            measuring_reg <= measuring_next;
            pulse_reg     <= pulse_next;
            width_reg     <= width_next;
        end
    end

    // A finishing item always leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && done |=> phase_reg == pwh_pkg::PH_IDLE)
        else $error("handshake not idle after finishing item");

    // A start item always enters sync at stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && action |=> phase_reg == pwh_pkg::PH_SYNC && !stage2_reg)
        else $error("start did not enter sync");

    // Pulse timing is never live during sync; a start clears it
    assert property (@(posedge clk) disable iff (!rst_n)
        measuring_reg |-> phase_reg != pwh_pkg::PH_SYNC)
        else $error("pulse timer active during sync phase");

    // Stage two is only reached through the wait phase
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == pwh_pkg::PH_SYNC |-> !stage2_reg)
        else $error("stage two set during sync");

endmodule

`default_nettype wire

### hw/rtl/pulse_width_handshake.sv
// Pulse-width handshake with a sensor over one shared line, one tick or start per item.
// An accepted item reaches its result through the input register and then the result register.
// Throughput: one item per cycle while result_stall is low; the state update is a single pass between the registers.
// Reset: asynchronous, active low; phase idle, timers clear, config registers to defaults.
// Depends on pwh_pkg, pwh_cfg and pwh_engine.
`default_nettype none

module pulse_width_handshake #(
    parameter int TIMER_BITS  = pwh_pkg::TIMER_BITS_DEF,
    parameter int WINDOW_BITS = pwh_pkg::WINDOW_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [pwh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pwh_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Tick/start channel
    input  wire logic                            tick_valid,
    output logic                                 tick_stall,
    input  wire logic                            action,
    input  wire logic                            line_low,
    // Result channel
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic                                 drive_low,
    output logic                                 busy_res,
    output logic                                 done_res,
    output logic      [2:0]                      status,
    output logic                                 stage,
    output logic      [pwh_pkg::LW_W-1:0]        last_width
);

    logic [WINDOW_BITS-1:0]   sync_width;
    logic [WINDOW_BITS-1:0]   first_min;
    logic [WINDOW_BITS-1:0]   first_max;
    logic [WINDOW_BITS-1:0]   second_min;
    logic [WINDOW_BITS-1:0]   second_max;
    logic [pwh_pkg::TO_W-1:0] first_timeout;
    logic [pwh_pkg::TO_W-1:0] second_timeout;

    logic              in_vld_reg;
    logic              action_reg;
    logic              line_low_reg;
    logic              out_vld_reg;
    pwh_pkg::result_t  res_reg;
    pwh_pkg::result_t  res_next;
    logic              advance;
    logic              accept;

    pwh_cfg #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sync_width     (sync_width),
        .first_min      (first_min),
        .first_max      (first_max),
        .second_min     (second_min),
        .second_max     (second_max),
        .first_timeout  (first_timeout),
        .second_timeout (second_timeout)
    );

    pwh_engine #(
        .TIMER_BITS  (TIMER_BITS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .action         (action_reg),
        .line_low       (line_low_reg),
        .sync_width     (sync_width),
        .first_min      (first_min),
        .first_max      (first_max),
        .second_min     (second_min),
        .second_max     (second_max),
        .first_timeout  (first_timeout),
        .second_timeout (second_timeout),
        .res            (res_next)
    );

    // Move the held item into the result register when that register frees up
    assign advance    = in_vld_reg && (!out_vld_reg || !result_stall);
    assign tick_stall = in_vld_reg && !advance;
    assign accept     = tick_valid && !tick_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg   <= action;
            line_low_reg <= line_low;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign drive_low    = res_reg.drive_low;
    assign busy_res     = res_reg.busy_res;
    assign done_res     = res_reg.done_res;
    assign status       = 3'(res_reg.status);
    assign stage        = res_reg.stage;
    assign last_width   = res_reg.last_width;

    // Every held item moves on in the same cycle that the result register is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && !result_stall |-> advance)
        else $error("held item not advanced into free result register");

    // An item can only be refused while one is already held
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> in_vld_reg && out_vld_reg)
        else $error("input stalled with room available");

    // A result appears in the cycle after an item advances
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("advanced item produced no result");

endmodule

`default_nettype wire
